### rtl/mpmc_pkg.sv
`timescale 1ns / 1ps
// Package for the multi-pattern match counter.
// Holds sizes, item types, operation and status codes and controller states.
// No dependencies.
package mpmc_pkg;

  localparam int NODES      = 1024;
  localparam int ALPHABET   = 26;
  localparam int PATTERNS   = 32;
  localparam int COUNT_BITS = 20;

  localparam int NODE_W  = $clog2(NODES);
  localparam int SYM_W   = 5;
  localparam int PIDX_W  = 5;
  localparam int PAT_W   = $clog2(PATTERNS + 1);
  localparam int ROW     = ALPHABET + 1;
  localparam int QCOL    = ALPHABET;
  localparam int C_DEPTH = NODES * ROW;
  localparam int C_AW    = $clog2(C_DEPTH);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_SYMBOL = 3'd1,
    OP_END    = 3'd2,
    OP_BUILD  = 3'd3,
    OP_TEXT   = 3'd4,
    OP_REPORT = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_COUNT     = 2'd0,
    ST_TRIE_FULL = 2'd1,
    ST_PAT_FULL  = 2'd2,
    ST_NOT_BUILT = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_INS,
    S_END,
    S_ROOT,
    S_ROOT_CHK,
    S_POP,
    S_POP_WAIT,
    S_FAIL_WAIT,
    S_CH,
    S_G,
    S_NODE,
    S_LINK,
    S_TXT,
    S_WALK,
    S_MAX,
    S_MAX_CHK,
    S_REP,
    S_REP_OUT,
    S_EMIT
  } state_e;

  typedef struct packed {
    op_e              operation;
    logic [SYM_W-1:0] symbol;
  } cmd_t;

  typedef struct packed {
    status_e               status;
    logic [PIDX_W-1:0]     pattern_index;
    logic [COUNT_BITS-1:0] hit_count;
    logic                  is_max;
    logic                  last;
  } res_t;

  typedef struct packed {
    logic [NODE_W-1:0]     fail;
    logic                  term;
    logic [COUNT_BITS-1:0] hits;
  } node_t;

endpackage

### rtl/multi_pattern_match_counter_top.sv
`timescale 1ns / 1ps
// Aho-Corasick multi-pattern match counter with trie and node state in memories.
// Depends on mpmc_pkg.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i / in_stall_o | in_data_i  (cmd_t)
//   out     | output    | out_valid_o / out_stall_i | out_data_o (res_t)
//
// One item is in work at a time. A text symbol also walks its failure chain node by
// node, a build pass visits every trie node, and a report reads every loaded pattern.
// Reset and the clear operation start a clearing pass over the
// transition memory, during which no item is accepted.
// A waiting result sits in the output register while the next item is taken.
module multi_pattern_match_counter_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  mpmc_pkg::cmd_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output mpmc_pkg::res_t out_data_o
);
  import mpmc_pkg::*;

  function automatic logic [C_AW-1:0] caddr(logic [NODE_W-1:0] node, logic [SYM_W-1:0] col);
    return C_AW'(node) * C_AW'(ROW) + C_AW'(col);
  endfunction

  logic [NODE_W-1:0] cmem [C_DEPTH];
  node_t             nmem [NODES];

  logic              c_re, c_we, n_re, n_we;
  logic [C_AW-1:0]   c_raddr, c_waddr;
  logic [NODE_W-1:0] c_wdata, c_rdata_q;
  logic [NODE_W-1:0] n_raddr, n_waddr;
  node_t             n_wdata, n_rdata_q;

  state_e                state_q, state_d;
  logic [C_AW-1:0]       clr_q, clr_d;
  logic [NODE_W-1:0]     nodes_q, nodes_d, ins_q, ins_d, mc_q, mc_d;
  logic [PAT_W-1:0]      pats_q, pats_d;
  logic                  built_q, built_d, spoil_q, spoil_d;
  logic [NODE_W-1:0]     head_q, head_d, tail_q, tail_d;
  logic [NODE_W-1:0]     k_q, k_d, f_q, f_d, ch_q, ch_d, g_q, g_d, j_q, j_d;
  logic [SYM_W-1:0]      col_q, col_d, sym_q, sym_d;
  logic [PIDX_W-1:0]     idx_q, idx_d;
  logic [COUNT_BITS-1:0] best_q, best_d;
  logic [NODE_W-1:0]     pend_q [PATTERNS];
  logic                  pend_we;
  res_t                  res_q, res_d;
  logic                  out_valid_q, out_valid_d, out_load;
  res_t                  out_q, out_d;
  logic                  out_free, in_acc, idx_last;

  always_ff @(posedge clk_i) begin
    if (c_we) cmem[c_waddr] <= c_wdata;
    if (c_re) c_rdata_q <= cmem[c_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (n_we) nmem[n_waddr] <= n_wdata;
    if (n_re) n_rdata_q <= nmem[n_raddr];
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign idx_last    = (PAT_W'(idx_q) == pats_q - PAT_W'(1));

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    nodes_d = nodes_q;
    ins_d   = ins_q;
    mc_d    = mc_q;
    pats_d  = pats_q;
    built_d = built_q;
    spoil_d = spoil_q;
    head_d  = head_q;
    tail_d  = tail_q;
    k_d     = k_q;
    f_d     = f_q;
    ch_d    = ch_q;
    g_d     = g_q;
    j_d     = j_q;
    col_d   = col_q;
    sym_d   = sym_q;
    idx_d   = idx_q;
    best_d  = best_q;
    res_d   = res_q;
    pend_we = 1'b0;
    out_load = 1'b0;
    out_d   = res_q;
    c_re    = 1'b0;
    c_raddr = '0;
    c_we    = 1'b0;
    c_waddr = '0;
    c_wdata = '0;
    n_re    = 1'b0;
    n_raddr = '0;
    n_we    = 1'b0;
    n_waddr = '0;
    n_wdata = '0;

    unique case (state_q)
      S_CLEAR: begin
        c_we    = 1'b1;
        c_waddr = clr_q;
        if (clr_q < C_AW'(NODES)) begin
          n_we    = 1'b1;
          n_waddr = clr_q[NODE_W-1:0];
        end
        clr_d = clr_q + C_AW'(1);
        if (clr_q == C_AW'(C_DEPTH - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          sym_d = in_data_i.symbol;
          case (in_data_i.operation)
            OP_CLEAR: begin
              clr_d   = '0;
              nodes_d = '0;
              ins_d   = '0;
              mc_d    = '0;
              pats_d  = '0;
              built_d = 1'b0;
              spoil_d = 1'b0;
              state_d = S_CLEAR;
            end
            OP_SYMBOL: begin
              if (!built_q && !spoil_q && in_data_i.symbol < SYM_W'(ALPHABET)) begin
                c_re    = 1'b1;
                c_raddr = caddr(ins_q, in_data_i.symbol);
                state_d = S_INS;
              end
            end
            OP_END: begin
              if (!built_q) begin
                if (spoil_q) begin
                  spoil_d = 1'b0;
                  ins_d   = '0;
                end else if (pats_q >= PAT_W'(PATTERNS)) begin
                  ins_d   = '0;
                  res_d   = '{ST_PAT_FULL, '0, '0, 1'b0, 1'b1};
                  state_d = S_EMIT;
                end else begin
                  pend_we = 1'b1;
                  n_re    = 1'b1;
                  n_raddr = ins_q;
                  state_d = S_END;
                end
              end
            end
            OP_BUILD: begin
              if (!built_q) begin
                col_d   = '0;
                head_d  = '0;
                tail_d  = '0;
                state_d = S_ROOT;
              end
            end
            OP_TEXT: begin
              if (built_q && in_data_i.symbol < SYM_W'(ALPHABET)) begin
                c_re    = 1'b1;
                c_raddr = caddr(mc_q, in_data_i.symbol);
                state_d = S_TXT;
              end
            end
            OP_REPORT: begin
              if (!built_q) begin
                res_d   = '{ST_NOT_BUILT, '0, '0, 1'b0, 1'b1};
                state_d = S_EMIT;
              end else if (pats_q != '0) begin
                idx_d   = '0;
                best_d  = '0;
                state_d = S_MAX;
              end
            end
            default: ;
          endcase
        end
      end
      S_INS: begin
        state_d = S_IDLE;
        if (c_rdata_q != '0) begin
          ins_d = c_rdata_q;
        end else if (nodes_q == NODE_W'(NODES - 1)) begin
          spoil_d = 1'b1;
          res_d   = '{ST_TRIE_FULL, '0, '0, 1'b0, 1'b1};
          state_d = S_EMIT;
        end else begin
          nodes_d = nodes_q + NODE_W'(1);
          ins_d   = nodes_q + NODE_W'(1);
          c_we    = 1'b1;
          c_waddr = caddr(ins_q, sym_q);
          c_wdata = nodes_q + NODE_W'(1);
        end
      end
      S_END: begin
        n_we    = 1'b1;
        n_waddr = ins_q;
        n_wdata = n_rdata_q;
        n_wdata.term = 1'b1;
        pats_d  = pats_q + PAT_W'(1);
        ins_d   = '0;
        state_d = S_IDLE;
      end
      S_ROOT: begin
        c_re    = 1'b1;
        c_raddr = caddr('0, col_q);
        state_d = S_ROOT_CHK;
      end
      S_ROOT_CHK: begin
        if (c_rdata_q != '0) begin
          c_we    = 1'b1;
          c_waddr = caddr(tail_q, SYM_W'(QCOL));
          c_wdata = c_rdata_q;
          tail_d  = tail_q + NODE_W'(1);
        end
        if (col_q == SYM_W'(ALPHABET - 1)) begin
          state_d = S_POP;
        end else begin
          col_d   = col_q + SYM_W'(1);
          state_d = S_ROOT;
        end
      end
      S_POP: begin
        if (head_q == tail_q) begin
          built_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          c_re    = 1'b1;
          c_raddr = caddr(head_q, SYM_W'(QCOL));
          head_d  = head_q + NODE_W'(1);
          state_d = S_POP_WAIT;
        end
      end
      S_POP_WAIT: begin
        k_d     = c_rdata_q;
        n_re    = 1'b1;
        n_raddr = c_rdata_q;
        state_d = S_FAIL_WAIT;
      end
      S_FAIL_WAIT: begin
        f_d     = n_rdata_q.fail;
        col_d   = '0;
        state_d = S_CH;
      end
      S_CH: begin
        c_re    = 1'b1;
        c_raddr = caddr(k_q, col_q);
        state_d = S_G;
      end
      S_G: begin
        ch_d    = c_rdata_q;
        c_re    = 1'b1;
        c_raddr = caddr(f_q, col_q);
        state_d = S_NODE;
      end
      S_NODE: begin
        g_d = c_rdata_q;
        if (ch_q != '0) begin
          c_we    = 1'b1;
          c_waddr = caddr(tail_q, SYM_W'(QCOL));
          c_wdata = ch_q;
          tail_d  = tail_q + NODE_W'(1);
          n_re    = 1'b1;
          n_raddr = ch_q;
          state_d = S_LINK;
        end else begin
          c_we    = 1'b1;
          c_waddr = caddr(k_q, col_q);
          c_wdata = c_rdata_q;
          col_d   = col_q + SYM_W'(1);
          state_d = (col_q == SYM_W'(ALPHABET - 1)) ? S_POP : S_CH;
        end
      end
      S_LINK: begin
        n_we    = 1'b1;
        n_waddr = ch_q;
        n_wdata = n_rdata_q;
        n_wdata.fail = g_q;
        col_d   = col_q + SYM_W'(1);
        state_d = (col_q == SYM_W'(ALPHABET - 1)) ? S_POP : S_CH;
      end
      S_TXT: begin
        mc_d = c_rdata_q;
        j_d  = c_rdata_q;
        if (c_rdata_q == '0) begin
          state_d = S_IDLE;
        end else begin
          n_re    = 1'b1;
          n_raddr = c_rdata_q;
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (n_rdata_q.term && n_rdata_q.hits != COUNT_MAX) begin
          n_we    = 1'b1;
          n_waddr = j_q;
          n_wdata = n_rdata_q;
          n_wdata.hits = n_rdata_q.hits + COUNT_BITS'(1);
        end
        j_d = n_rdata_q.fail;
        if (n_rdata_q.fail == '0) begin
          state_d = S_IDLE;
        end else begin
          n_re    = 1'b1;
          n_raddr = n_rdata_q.fail;
        end
      end
      S_MAX: begin
        n_re    = 1'b1;
        n_raddr = pend_q[idx_q];
        state_d = S_MAX_CHK;
      end
      S_MAX_CHK: begin
        if (n_rdata_q.hits > best_q) best_d = n_rdata_q.hits;
        if (idx_last) begin
          idx_d   = '0;
          state_d = S_REP;
        end else begin
          idx_d   = idx_q + PIDX_W'(1);
          state_d = S_MAX;
        end
      end
      S_REP: begin
        n_re    = 1'b1;
        n_raddr = pend_q[idx_q];
        state_d = S_REP_OUT;
      end
      S_REP_OUT: begin
        out_d = '{ST_COUNT, idx_q, n_rdata_q.hits, n_rdata_q.hits == best_q, idx_last};
        if (out_free) begin
          out_load = 1'b1;
          idx_d    = idx_q + PIDX_W'(1);
          state_d  = idx_last ? S_IDLE : S_REP;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    out_valid_d = out_load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      nodes_q     <= '0;
      ins_q       <= '0;
      mc_q        <= '0;
      pats_q      <= '0;
      built_q     <= 1'b0;
      spoil_q     <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      col_q       <= '0;
      idx_q       <= '0;
      best_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      nodes_q     <= nodes_d;
      ins_q       <= ins_d;
      mc_q        <= mc_d;
      pats_q      <= pats_d;
      built_q     <= built_d;
      spoil_q     <= spoil_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      col_q       <= col_d;
      idx_q       <= idx_d;
      best_q      <= best_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q   <= k_d;
    f_q   <= f_d;
    ch_q  <= ch_d;
    g_q   <= g_d;
    j_q   <= j_d;
    sym_q <= sym_d;
    res_q <= res_d;
    if (out_load) out_q <= out_d;
    if (pend_we) pend_q[pats_q[PIDX_W-1:0]] <= ins_q;
  end

  // The insertion cursor always points at an allocated node.
  assert property (@(posedge clk_i) disable iff (!rst_ni) ins_q <= nodes_q)
    else $error("insert cursor beyond allocated nodes");

  // The breadth-first queue never reads past its tail.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP_WAIT) |-> (head_q <= tail_q))
    else $error("queue head passed tail");

  // Text items walk the automaton only once links are built.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TXT || state_q == S_WALK) |-> built_q)
    else $error("text walk before build");

  // The pattern table never holds more than its capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pats_q <= PAT_W'(PATTERNS))
    else $error("pattern count overflow");

endmodule
